/* hdl/epr_pkg.sv */
// ----------------------------------------------------------------------------
// epr_pkg
// Shared sizes, codes and types of the rotate-XOR entropy pool.
// ----------------------------------------------------------------------------
package epr_pkg;

    // Pool geometry
    localparam int POOL_BYTES   = 32;
    localparam int POOL_BITS    = POOL_BYTES * 8;
    localparam int AW           = $clog2(POOL_BYTES);
    localparam int EST_W        = $clog2(POOL_BITS + 1);
    localparam int DLV_W        = $clog2(POOL_BYTES + 1);
    localparam int EVENT_BYTES  = 8;
    localparam int JITTER_BYTES = 2;
    localparam int CNT_W        = (DLV_W > 4) ? DLV_W : 4;
    localparam int MIX_W        = EVENT_BYTES * 8;
    localparam int PHASE_W      = 3;

    // Configuration register
    localparam int MIN_W                  = 9;
    localparam int PADDR_W                = 3;
    localparam logic [MIN_W-1:0] MIN_BITS_RESET = 9'd128;
    localparam logic             REG_MIN_BITS   = 1'b0;

    // Input function codes
    typedef enum logic [1:0] {
        FUNC_EVENT   = 2'd0,
        FUNC_JITTER  = 2'd1,
        FUNC_EXTRACT = 2'd2,
        FUNC_STATUS  = 2'd3
    } t_func;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_REFUSED = 2'd2
    } t_kind;

endpackage

/* hdl/entropy_pool_rotxor.sv */
// ----------------------------------------------------------------------------
// entropy_pool_rotxor
// Entropy pool mixed by rotate-XOR, with an APB register for the extract
// threshold.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     func, source_irq, timestamp,
//                                                    jitter_value, request_bytes
//   out       output     o_out_valid / i_out_ready   kind, data_byte, delivered,
//                                                    bit_estimate, event_count, last
//   apb       input      psel, penable, pwrite       paddr, pwdata -> prdata
//
// Mixing: one pool byte per cycle through the pipelined read-modify-write of
//   the pool RAM; a new item is accepted only once the previous one is done.
// Extract: each delivered byte takes a read step, then a step that writes it back and loads the result.
// Reset: synchronous; pool bytes read as zero through per-byte written flags,
//   so no clearing pass is needed.
// Stalls: a full result register holds extract between bytes and holds status and refusal
//   results; mixing items produce no result and never wait on the output side.
// ----------------------------------------------------------------------------
module entropy_pool_rotxor
    import epr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item input
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [7:0]         i_source_irq,
    input  logic [31:0]        i_timestamp,
    input  logic [15:0]        i_jitter_value,
    input  logic [7:0]         i_request_bytes,
    // result output
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_data_byte,
    output logic [DLV_W-1:0]   o_delivered,
    output logic [EST_W-1:0]   o_bit_estimate,
    output logic [31:0]        o_event_count,
    output logic               o_last,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [MIN_W-1:0] r_min_bits;
    logic             apb_wr;
    logic             sel_min;

    assign sel_min = (paddr[PADDR_W-1:2] == REG_MIN_BITS);
    assign apb_wr  = psel && penable && pwrite;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_bits <= MIN_BITS_RESET;
        end else if (apb_wr && sel_min) begin
            r_min_bits <= pwdata[MIN_W-1:0];
        end
    end

    // Read back
    assign prdata = sel_min ? 32'(r_min_bits) : 32'd0;
    assign pready = 1'b1;

    epr_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_min_bits      (r_min_bits),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_source_irq    (i_source_irq),
        .i_timestamp     (i_timestamp),
        .i_jitter_value  (i_jitter_value),
        .i_request_bytes (i_request_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_delivered     (o_delivered),
        .o_bit_estimate  (o_bit_estimate),
        .o_event_count   (o_event_count),
        .o_last          (o_last)
    );

endmodule

/* hdl/epr_ram.sv */
// ----------------------------------------------------------------------------
// epr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module epr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/epr_core.sv */
// ----------------------------------------------------------------------------
// epr_core
// Sequencer of the pool: one read-modify-write per pool byte, estimate and
// counters, and the result register.
// ----------------------------------------------------------------------------
module epr_core
    import epr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [MIN_W-1:0] i_min_bits,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_source_irq,
    input  logic [31:0]      i_timestamp,
    input  logic [15:0]      i_jitter_value,
    input  logic [7:0]       i_request_bytes,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [DLV_W-1:0] o_delivered,
    output logic [EST_W-1:0] o_bit_estimate,
    output logic [31:0]      o_event_count,
    output logic             o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_EX_RD,
        S_EX_WR,
        S_RESP
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_wpos;
    logic [EST_W-1:0]    r_est;
    logic [31:0]         r_evc;
    logic [31:0]         r_prev;
    logic [PHASE_W-1:0]  r_phase;
    logic [POOL_BYTES-1:0] r_vld;

    logic [MIX_W-1:0]    r_mix;
    logic [AW-1:0]       r_addr;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_len;
    logic [DLV_W-1:0]    r_dlv;
    t_kind               r_resp_kind;

    logic                r_w_valid;
    logic [AW-1:0]       r_w_addr;
    logic [7:0]          r_w_byte;
    logic                r_w_rot;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [7:0]          r_data;
    logic [DLV_W-1:0]    r_odlv;
    logic [EST_W-1:0]    r_oest;
    logic [31:0]         r_oevc;
    logic                r_last;

    logic [7:0]          ram_rdata;
    logic [7:0]          rd_byte;
    logic [7:0]          n_byte;
    logic [AW-1:0]       addr_inc;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_free;
    logic [EST_W-1:0]    est_bump;
    logic [DLV_W-1:0]    ex_len;
    logic [EST_W-1:0]    ex_charge;
    logic [31:0]         delta;
    logic                n_w_valid;
    logic                n_out_valid;

    // Pool storage
    epr_ram #(
        .WIDTH (8),
        .DEPTH (POOL_BYTES)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (r_w_valid),
        .i_waddr (r_w_addr),
        .i_wdata (n_byte),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Never-written bytes read as zero
    assign rd_byte = r_vld[r_w_addr] ? ram_rdata : 8'h00;

    // Modify step: rotate left by one for events, plain XOR otherwise
    assign n_byte = r_w_rot ? ({rd_byte[6:0], rd_byte[7]} ^ r_w_byte)
                            : (rd_byte ^ r_w_byte);

    assign addr_inc  = (r_addr == AW'(POOL_BYTES - 1)) ? '0 : r_addr + 1'b1;
    assign cnt_next  = r_cnt + 1'b1;
    assign out_free  = !r_out_valid || i_out_ready;
    assign est_bump  = (r_est < EST_W'(POOL_BITS)) ? r_est + 1'b1 : r_est;
    assign delta     = i_timestamp - r_prev;

    // Clamp the extract request to the pool size and price it
    assign ex_len    = (32'(i_request_bytes) > 32'(POOL_BYTES)) ? DLV_W'(POOL_BYTES)
                                                                : DLV_W'(i_request_bytes);
    assign ex_charge = EST_W'({ex_len, 3'b000});

    // Write strobe for each mixed or remixed byte
    assign n_w_valid   = (r_state == S_MIX) || ((r_state == S_EX_RD) && out_free);

    // Load a new result, else hold the current one until it is transferred
    assign n_out_valid = (r_state == S_EX_WR) || ((r_state == S_RESP) && out_free)
                         || (r_out_valid && !i_out_ready);

    // Sequencer, pool state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wpos      <= '0;
            r_est       <= '0;
            r_evc       <= '0;
            r_prev      <= '0;
            r_phase     <= '0;
            r_vld       <= '0;
            r_w_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_w_valid   <= n_w_valid;
            r_out_valid <= n_out_valid;
            // mark written bytes
            if (r_w_valid) begin
                r_vld[r_w_addr] <= 1'b1;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt  <= '0;
                        r_addr <= r_wpos;
                        unique case (t_func'(i_func))
                            FUNC_EVENT: begin
                                if (i_source_irq != 8'd0) begin
                                    r_prev  <= i_timestamp;
                                    r_evc   <= r_evc + 1'b1;
                                    r_est   <= est_bump;
                                    r_mix   <= {delta, i_timestamp};
                                    r_w_rot <= 1'b1;
                                    r_len   <= CNT_W'(EVENT_BYTES);
                                    r_state <= S_MIX;
                                end
                            end
                            FUNC_JITTER: begin
                                r_mix   <= MIX_W'(i_jitter_value);
                                r_w_rot <= 1'b0;
                                r_len   <= CNT_W'(JITTER_BYTES);
                                if (r_phase == '1) begin
                                    r_est <= est_bump;
                                end
                                r_phase <= r_phase + 1'b1;
                                r_state <= S_MIX;
                            end
                            FUNC_EXTRACT: begin
                                if (i_request_bytes == 8'd0) begin
                                    r_resp_kind <= KIND_STATUS;
                                    r_state     <= S_RESP;
                                end else if (r_est < i_min_bits) begin
                                    r_resp_kind <= KIND_REFUSED;
                                    r_state     <= S_RESP;
                                end else begin
                                    r_est   <= (r_est > ex_charge) ? r_est - ex_charge : '0;
                                    r_len   <= CNT_W'(ex_len);
                                    r_dlv   <= ex_len;
                                    r_mix   <= MIX_W'(i_timestamp[7:0]);
                                    r_w_rot <= 1'b0;
                                    r_state <= S_EX_RD;
                                end
                            end
                            FUNC_STATUS: begin
                                r_resp_kind <= KIND_STATUS;
                                r_state     <= S_RESP;
                            end
                        endcase
                    end
                end

                // issue one read a cycle; the write follows in the next cycle
                S_MIX: begin
                    r_w_addr  <= r_addr;
                    r_w_byte  <= r_mix[7:0];
                    r_mix     <= r_mix >> 8;
                    r_addr    <= addr_inc;
                    r_wpos    <= addr_inc;
                    r_cnt     <= cnt_next;
                    if (cnt_next == r_len) begin
                        r_state <= S_IDLE;
                    end
                end

                // read the next byte only when the result register can take it
                S_EX_RD: begin
                    if (out_free) begin
                        r_w_addr  <= r_addr;
                        r_w_byte  <= r_mix[7:0];
                        r_state   <= S_EX_WR;
                    end
                end

                // deliver the old byte while the remixed one is written back
                S_EX_WR: begin
                    r_kind      <= KIND_DATA;
                    r_data      <= rd_byte;
                    r_odlv      <= r_dlv;
                    r_oest      <= r_est;
                    r_oevc      <= r_evc;
                    r_last      <= (cnt_next == r_len);
                    r_cnt       <= cnt_next;
                    r_addr      <= addr_inc;
                    r_state     <= (cnt_next == r_len) ? S_IDLE : S_EX_RD;
                end

                // single status or refusal result
                S_RESP: begin
                    if (out_free) begin
                        r_kind      <= r_resp_kind;
                        r_data      <= 8'h00;
                        r_odlv      <= '0;
                        r_oest      <= r_est;
                        r_oevc      <= r_evc;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_data_byte    = r_data;
    assign o_delivered    = r_odlv;
    assign o_bit_estimate = r_oest;
    assign o_event_count  = r_oevc;
    assign o_last         = r_last;

endmodule
